// ----- design/srmr_pkg.sv -----
// package: sizes, codes and shared types for the mapped-register ram
`timescale 1ns / 1ps
`default_nettype none
package srmr_pkg;

	localparam int unsigned MEM_BYTES  = 65536;
	localparam int unsigned NUM_REGS   = 16;
	localparam int unsigned BANK_WORDS = (MEM_BYTES + 3) / 4;
	localparam int unsigned BANK_IDX_W = $clog2(BANK_WORDS);
	localparam int unsigned REG_IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int unsigned REG_BYTES  = NUM_REGS * 4;

	localparam logic       REQ_WRITE   = 1'b1;

	localparam logic [1:0] SZ_BYTE     = 2'd0;
	localparam logic [1:0] SZ_HALF     = 2'd1;
	localparam logic [1:0] SZ_WORD     = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_MISALIGN = 2'd2;

	typedef struct packed {
		logic               req_type;
		logic [1:0]         access_size;
		logic [31:0]        address;
		logic signed [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_data;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_RESPOND
	} state_t;

	typedef struct packed {
		logic clear;
		logic issue;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} sts_t;

endpackage
`default_nettype wire

// ----- design/sized_ram_with_mapped_registers.sv -----
// top level: byte-addressed ram with mapped register file and trap checks
`timescale 1ns / 1ps
`default_nettype none
// The request is taken on the edge where start is high and busy low, and the
// result is on rsp for the next cycle only, marked by done, while busy stays
// high; the bank memory read that feeds it is registered. The receiver cannot
// hold results off. After reset the bank is swept to zero, one word a cycle,
// all 16384 words (MEM_BYTES/4), with busy high before the first request is taken.
module sized_ram_with_mapped_registers (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire srmr_pkg::req_t req,
	output logic                done,
	output srmr_pkg::rsp_t      rsp
);
	import srmr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	srmr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	srmr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

	a_accept_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done && busy)
		else $error("accepted beat not answered in the next cycle");

	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not followed by idle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_OK || rsp.status == ST_RANGE || rsp.status == ST_MISALIGN))
		else $error("undefined status code");

	a_trap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.read_data == '0)
		else $error("trapped beat returned data");

endmodule
`default_nettype wire

// ----- design/srmr_dp.sv -----
// datapath: request capture, trap checks, register file, bank memory and lane logic
`timescale 1ns / 1ps
`default_nettype none
module srmr_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire srmr_pkg::cmd_t cmd,
	output srmr_pkg::sts_t     sts,
	input  wire srmr_pkg::req_t req,
	output srmr_pkg::rsp_t     rsp
);
	import srmr_pkg::*;

	logic [31:0]           bank_q [BANK_WORDS];
	logic [31:0]           regs_q [NUM_REGS];
	logic [31:0]           bank_rd_q;
	req_t                  req_q;
	logic [1:0]            status_q;
	logic [BANK_IDX_W-1:0] clr_q;

	logic [1:0]            status_d;
	logic                  in_regs;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic [BANK_IDX_W-1:0] bank_idx;
	logic [31:0]           old_word;
	logic [4:0]            shift;
	logic [31:0]           lane;
	logic [31:0]           old_lane;
	logic [31:0]           old_ext;
	logic [31:0]           new_word;
	logic                  access_ok;
	logic                  wr_en;

	// trap checks: range first, then size and alignment
	always_comb begin
		if (req.address >= 32'(MEM_BYTES)) begin
			status_d = ST_RANGE;
		end else if ((req.access_size != SZ_BYTE && req.access_size != SZ_HALF &&
				req.access_size != SZ_WORD) ||
				(req.access_size == SZ_WORD && req.address[1:0] != 2'b00) ||
				(req.access_size == SZ_HALF && req.address[0])) begin
			status_d = ST_MISALIGN;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			req_q    <= req;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_q == BANK_IDX_W'(BANK_WORDS - 1));

	assign in_regs   = (req_q.address < 32'(REG_BYTES));
	assign reg_idx   = req_q.address[REG_IDX_W+1:2];
	assign bank_idx  = req_q.address[BANK_IDX_W+1:2];
	assign old_word  = in_regs ? regs_q[reg_idx] : bank_rd_q;
	assign shift     = {req_q.address[1:0], 3'b000};
	assign access_ok = (status_q == ST_OK);
	assign wr_en     = cmd.commit && access_ok && (req_q.req_type == REQ_WRITE);

	always_comb begin
		case (req_q.access_size)
			SZ_BYTE: lane = 32'h0000_00ff << shift;
			SZ_HALF: lane = 32'h0000_ffff << shift;
			default: lane = 32'hffff_ffff;
		endcase
		old_lane = (old_word & lane) >> shift;
		case (req_q.access_size)
			SZ_BYTE: old_ext = {{24{old_lane[7]}}, old_lane[7:0]};
			SZ_HALF: old_ext = {{16{old_lane[15]}}, old_lane[15:0]};
			default: old_ext = old_lane;
		endcase
		new_word = (old_word & ~lane) | (($unsigned(req_q.write_data) << shift) & lane);
	end

	// bank memory: one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			bank_q[clr_q] <= '0;
		end else if (wr_en && !in_regs) begin
			bank_q[bank_idx] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			bank_rd_q <= bank_q[req.address[BANK_IDX_W+1:2]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr_en && in_regs) begin
			regs_q[reg_idx] <= new_word;
		end
	end

	assign rsp.read_data = access_ok ? $signed(old_ext) : '0;
	assign rsp.status    = status_q;

endmodule
`default_nettype wire

// ----- design/srmr_ctrl.sv -----
// controller: clearing pass, accept and response sequencing
`timescale 1ns / 1ps
`default_nettype none
module srmr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output logic                done,
	output srmr_pkg::cmd_t      cmd,
	input  wire srmr_pkg::sts_t sts
);
	import srmr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.issue = 1'b1;
					state_d   = S_RESPOND;
				end
			end
			S_RESPOND: begin
				cmd.commit = 1'b1;
				done       = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule
`default_nettype wire
